@@ sv/crcfb_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the frame builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package crcfb_pkg;

   // Frame layout and CRC constants
   localparam logic [7:0]  MAX_PAYLOAD = 8'd32;
   localparam logic [7:0]  BASE_LEN    = 8'd7;
   localparam logic [7:0]  WRITE_EXTRA = 8'd2;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   // Stream widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Action and frame kind codes
   localparam logic       ACT_BEGIN     = 1'b0;
   localparam logic       ACT_PAYLOAD   = 1'b1;
   localparam logic [1:0] KIND_PING     = 2'd0;
   localparam logic [1:0] KIND_READ     = 2'd1;
   localparam logic [1:0] KIND_WRITE    = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PING   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE  = 2'd3;

   typedef struct packed {
      logic [15:0] header_word;
      logic [7:0]  ping_code;
      logic [7:0]  read_code;
      logic [7:0]  write_code;
   } cfg_type;

   // One byte offered to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       frame_end;
   } emit_type;

   // Reflected CRC-16 update over one byte, eight bit steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/crcfb_csr.sv @@
// Configuration registers: header word and the three opcodes.
// Depends on crcfb_pkg.
`default_nettype none

module crcfb_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [crcfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [crcfb_pkg::CSR_DATA_W-1:0] csr_data,
   output crcfb_pkg::cfg_type                   cfg
);
   import crcfb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HEADER: cfg_in.header_word = csr_data;
            CSR_PING:   cfg_in.ping_code   = csr_data[7:0];
            CSR_READ:   cfg_in.read_code   = csr_data[7:0];
            CSR_WRITE:  cfg_in.write_code  = csr_data[7:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_word <= 16'hFFFF;
         cfg_ff.ping_code   <= 8'd1;
         cfg_ff.read_code   <= 8'd2;
         cfg_ff.write_code  <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/crcfb_seq.sv @@
// Item register and byte sequencer: frame state, length, opcode and running CRC.
// Depends on crcfb_pkg (cfg_type, emit_type, crc_byte).
`default_nettype none

module crcfb_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               action,
   input  wire logic [1:0]         frame_kind,
   input  wire logic [7:0]         slave_addr,
   input  wire logic [7:0]         reg_addr,
   input  wire logic [5:0]         payload_count,
   input  wire logic [7:0]         data_byte,
   input  crcfb_pkg::cfg_type      cfg,
   input  wire logic               out_free,
   output crcfb_pkg::emit_type     emit
);
   import crcfb_pkg::*;

   typedef enum logic [9:0] {
      ST_HDR_LO = 10'b00_0000_0001,
      ST_HDR_HI = 10'b00_0000_0010,
      ST_SLAVE  = 10'b00_0000_0100,
      ST_LEN    = 10'b00_0000_1000,
      ST_CODE   = 10'b00_0001_0000,
      ST_REG    = 10'b00_0010_0000,
      ST_COUNT  = 10'b00_0100_0000,
      ST_DATA   = 10'b00_1000_0000,
      ST_CRC_LO = 10'b01_0000_0000,
      ST_CRC_HI = 10'b10_0000_0000
   } step_type;

   step_type    step_ff, step_in, step_next;
   logic        busy_ff, busy_in;
   logic        frame_open_ff, frame_open_in;
   logic [5:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;
   logic        write_ff, write_in;
   logic        close_ff, close_in;
   logic [7:0]  slave_ff, slave_in;
   logic [7:0]  reg_ff, reg_in;
   logic [5:0]  n_ff, n_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  data_ff, data_in;

   logic        kind_ok, produces, accept, emit_fire, last;
   logic [5:0]  n_sat, n_eff, left_dec;
   logic [7:0]  cur_byte;

   // Decode of the incoming item against the frame state
   always_comb begin
      n_sat    = ({2'b00, payload_count} > MAX_PAYLOAD) ? MAX_PAYLOAD[5:0] : payload_count;
      n_eff    = (frame_kind == KIND_PING) ? 6'd0 : n_sat;
      left_dec = (bytes_left_ff != 6'd0) ? bytes_left_ff - 6'd1 : 6'd0;
      kind_ok  = (frame_kind != KIND_RESERVED);
      produces = (action == ACT_BEGIN) ? kind_ok : frame_open_ff;
   end

   // Last byte of the current item
   always_comb begin
      last = 1'b0;
      unique case (step_ff)
         ST_CODE:   last = !write_ff && !close_ff;
         ST_COUNT:  last = !close_ff;
         ST_DATA:   last = !close_ff;
         ST_CRC_HI: last = 1'b1;
         default:   last = 1'b0;
      endcase
   end

   assign emit_fire = busy_ff && out_free;
   assign req_ready = !busy_ff || (emit_fire && last);
   assign accept    = req_valid && req_ready;

   // Byte select and step order
   always_comb begin
      cur_byte  = data_ff;
      step_next = ST_HDR_LO;
      unique case (step_ff)
         ST_HDR_LO: begin
            cur_byte  = cfg.header_word[7:0];
            step_next = ST_HDR_HI;
         end
         ST_HDR_HI: begin
            cur_byte  = cfg.header_word[15:8];
            step_next = ST_SLAVE;
         end
         ST_SLAVE: begin
            cur_byte  = slave_ff;
            step_next = ST_LEN;
         end
         ST_LEN: begin
            cur_byte  = len_ff;
            step_next = ST_CODE;
         end
         ST_CODE: begin
            cur_byte  = code_ff;
            step_next = write_ff ? ST_REG : ST_CRC_LO;
         end
         ST_REG: begin
            cur_byte  = reg_ff;
            step_next = ST_COUNT;
         end
         ST_COUNT: begin
            cur_byte  = {2'b00, n_ff};
            step_next = ST_CRC_LO;
         end
         ST_DATA: begin
            cur_byte  = data_ff;
            step_next = ST_CRC_LO;
         end
         ST_CRC_LO: begin
            cur_byte  = crc_ff[7:0];
            step_next = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            cur_byte  = crc_ff[15:8];
            step_next = ST_HDR_LO;
         end
         default: begin
            cur_byte  = data_ff;
            step_next = ST_HDR_LO;
         end
      endcase
   end

   assign emit.valid     = emit_fire;
   assign emit.out_byte  = cur_byte;
   assign emit.frame_end = (step_ff == ST_CRC_HI);

   // Running CRC over the bytes as they go out
   always_comb begin
      crc_in = crc_ff;
      if (emit_fire) begin
         unique case (step_ff)
            ST_HDR_LO: crc_in = crc_byte(CRC_INIT, cur_byte);
            ST_CRC_LO: crc_in = crc_ff;
            ST_CRC_HI: crc_in = CRC_INIT;
            default:   crc_in = crc_byte(crc_ff, cur_byte);
         endcase
      end
   end

   // Item register load and frame state update at transfer
   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      write_in      = write_ff;
      close_in      = close_ff;
      slave_in      = slave_ff;
      reg_in        = reg_ff;
      n_in          = n_ff;
      len_in        = len_ff;
      code_in       = code_ff;
      data_in       = data_ff;

      if (emit_fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_next;
         end
      end

      if (accept && produces) begin
         busy_in = 1'b1;
         if (action == ACT_BEGIN) begin
            step_in       = ST_HDR_LO;
            write_in      = (frame_kind == KIND_WRITE);
            close_in      = (n_eff == 6'd0);
            frame_open_in = (n_eff != 6'd0);
            bytes_left_in = n_eff;
            slave_in      = slave_addr;
            reg_in        = reg_addr;
            n_in          = n_eff;
            len_in        = BASE_LEN + {2'b00, n_eff}
                            + ((frame_kind == KIND_WRITE) ? WRITE_EXTRA : 8'd0);
            case (frame_kind)
               KIND_PING:  code_in = cfg.ping_code;
               KIND_READ:  code_in = cfg.read_code;
               default:    code_in = cfg.write_code;
            endcase
         end else begin
            step_in       = ST_DATA;
            write_in      = 1'b0;
            close_in      = (left_dec == 6'd0);
            frame_open_in = (left_dec != 6'd0);
            bytes_left_in = left_dec;
            data_in       = data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= ST_HDR_LO;
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 6'd0;
         crc_ff        <= CRC_INIT;
      end else begin
         busy_ff       <= busy_in;
         step_ff       <= step_in;
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      write_ff <= write_in;
      close_ff <= close_in;
      slave_ff <= slave_in;
      reg_ff   <= reg_in;
      n_ff     <= n_in;
      len_ff   <= len_in;
      code_ff  <= code_in;
      data_ff  <= data_in;
   end

endmodule

`default_nettype wire

@@ sv/crcfb_out.sv @@
// Output register of the result stream; holds a byte until its transfer.
// Depends on crcfb_pkg (emit_type).
`default_nettype none

module crcfb_out (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  crcfb_pkg::emit_type                  emit,
   output logic                                 out_free,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [crcfb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);
   import crcfb_pkg::*;

   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] byte_ff, byte_in;
   logic                  last_ff, last_in;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

   // Load when empty or the held byte transfers this cycle
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = emit.valid;
         if (emit.valid) begin
            byte_in = emit.out_byte;
            last_in = emit.frame_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

@@ sv/crc16_command_frame_builder.sv @@
// Top level of the CRC-16/MODBUS command frame builder.
// Depends on crcfb_pkg, crcfb_csr, crcfb_seq and crcfb_out.
//
// Channel  Dir  Handshake               Content
// req      in   req_tvalid/req_tready   tuser {frame_kind, action}, tdata item fields
// rsp      out  rsp_tvalid/rsp_tready   tdata out_byte, tlast frame_end
// csr      in   csr_valid/csr_ready     csr_index, csr_data
// Reset is synchronous, active high. A stall on rsp holds the byte and stalls req;
// otherwise the output register moves one byte per cycle, and that sets the rate.
// A ping or read begin emits header, slave, length and opcode, a write begin also
// register address and payload count, then the CRC if there is no payload; a payload
// item emits its data byte, then the CRC if it closes the frame. The next item is
// taken in the cycle the last byte of the previous one enters the output register.
`default_nettype none

module crc16_command_frame_builder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] slave_addr, [15:8] reg_addr, [21:16] payload_count, [29:22] data_byte
   input  wire logic [crcfb_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] action, [2:1] frame_kind
   input  wire logic [crcfb_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [7:0] out_byte
   output logic [crcfb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [crcfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [crcfb_pkg::CSR_DATA_W-1:0] csr_data
);
   import crcfb_pkg::*;

   cfg_type  cfg;
   emit_type emit;
   logic     out_free;

   crcfb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crcfb_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .action        (req_tuser[0]),
      .frame_kind    (req_tuser[2:1]),
      .slave_addr    (req_tdata[7:0]),
      .reg_addr      (req_tdata[15:8]),
      .payload_count (req_tdata[21:16]),
      .data_byte     (req_tdata[29:22]),
      .cfg           (cfg),
      .out_free      (out_free),
      .emit          (emit)
   );

   crcfb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ sv/crcfb_checker.sv @@
// Port-level checks on the frame builder, attached to the top level by bind.
// Depends on crcfb_pkg for widths and codes.
`default_nettype none

module crcfb_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [crcfb_pkg::REQ_USER_W-1:0] req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [crcfb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tlast
);
   import crcfb_pkg::*;

   // A stalled result byte holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp byte changed while stalled");

   // Output register is empty after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // A begin of a known kind shows output after it passes the item and output registers
   a_begin_out: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == ACT_BEGIN)
      && (req_tuser[2:1] != KIND_RESERVED) |=> ##1 rsp_tvalid)
      else $error("begin transfer gave no output");

   // Input is held off once a begin of a known kind is taken, while its header is serialized
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == ACT_BEGIN)
      && (req_tuser[2:1] != KIND_RESERVED) |=> !req_tready)
      else $error("input taken during header serialization");

endmodule

bind crc16_command_frame_builder crcfb_checker u_checker (.*);

`default_nettype wire
